@@ rtl/html_tag_stripper_macros.svh @@
// assertion macros for the html tag stripper checker
// no dependencies; included by the checker file only
`ifndef HTML_TAG_STRIPPER_MACROS_SVH
`define HTML_TAG_STRIPPER_MACROS_SVH

// same-cycle implication, masked during reset
`define HTS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define HTS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hts_pkg.sv @@
// shared types and constants of the html tag stripper
// no dependencies; used by hts_cell, hts_outq and html_tag_stripper
`default_nettype none

package hts_pkg;

  localparam int WIN_DEPTH = 9;
  localparam int NUM_PAT   = 4;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] fill_t;
  typedef logic [NUM_PAT-1:0][7:0] pat_col_t;
  typedef logic [NUM_PAT-1:0] pat_hit_t;

  typedef struct packed {
    byte_t out_byte;
    logic  byte_valid;
    logic  run_last;
    logic  text_end;
  } res_t;

  // pattern slots
  localparam int P_SCRIPT_OPEN  = 0;
  localparam int P_SCRIPT_CLOSE = 1;
  localparam int P_STYLE_OPEN   = 2;
  localparam int P_STYLE_CLOSE  = 3;

  localparam fill_t LEN_SCRIPT_OPEN  = 4'd7;
  localparam fill_t LEN_SCRIPT_CLOSE = 4'd9;
  localparam fill_t LEN_STYLE_OPEN   = 4'd6;
  localparam fill_t LEN_STYLE_CLOSE  = 4'd8;

  localparam fill_t FILL_FULL = 4'd9;

  localparam logic [0:WIN_DEPTH-1][7:0] PAT_SCRIPT_OPEN  = {"<script", 16'h0000};
  localparam logic [0:WIN_DEPTH-1][7:0] PAT_SCRIPT_CLOSE = {"</script>"};
  localparam logic [0:WIN_DEPTH-1][7:0] PAT_STYLE_OPEN   = {"<style", 24'h000000};
  localparam logic [0:WIN_DEPTH-1][7:0] PAT_STYLE_CLOSE  = {"</style>", 8'h00};

  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_SPACE = 8'h20;

  localparam fill_t SKIP_SCRIPT = 4'd8;
  localparam fill_t SKIP_STYLE  = 4'd7;

  function automatic pat_col_t pat_col(input int pos);
    pat_col_t col;
    col[P_SCRIPT_OPEN]  = PAT_SCRIPT_OPEN[pos];
    col[P_SCRIPT_CLOSE] = PAT_SCRIPT_CLOSE[pos];
    col[P_STYLE_OPEN]   = PAT_STYLE_OPEN[pos];
    col[P_STYLE_CLOSE]  = PAT_STYLE_CLOSE[pos];
    return col;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hts_ifs.sv @@
// valid/ready channel interfaces of the html tag stripper
// no dependencies beyond plain logic types
`default_nettype none

interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input text_end, output ready);
endinterface

`default_nettype wire

@@ rtl/hts_cell.sv @@
// one position of the lookahead window: byte register and pattern compare
// depends on hts_pkg
`default_nettype none

module hts_cell (
  input  wire              clk,
  input  wire              wr_i,
  input  wire              shift_i,
  input  hts_pkg::byte_t   nb_i,
  input  hts_pkg::byte_t   in_byte_i,
  input  hts_pkg::pat_col_t pat_i,
  output hts_pkg::byte_t   data_o,
  output hts_pkg::pat_hit_t hit_o
);
  import hts_pkg::*;

  byte_t data_r;
  byte_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (wr_i) begin
      data_nxt = in_byte_i;
    end else if (shift_i) begin
      data_nxt = nb_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    for (int p = 0; p < NUM_PAT; p++) begin
      hit_o[p] = (data_r == pat_i[p]);
    end
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

@@ rtl/hts_outq.sv @@
// two-entry result queue driving the output channel
// depends on hts_pkg and hts_ifs
`default_nettype none

module hts_outq (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push_i,
  input  hts_pkg::res_t data_i,
  output logic          full_o,
  hts_out_if.source     out_ch
);
  import hts_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic       pop;
  logic [1:0] slot;

  assign pop  = out_ch.valid && out_ch.ready;
  assign slot = cnt_r - {1'b0, pop};

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r + {1'b0, push_i} - {1'b0, pop};
    if (pop) begin
      e0_nxt = e1_r;
    end
    if (push_i) begin
      if (slot == 2'd0) begin
        e0_nxt = data_i;
      end else begin
        e1_nxt = data_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign full_o            = (cnt_r == 2'd2);
  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.out_byte   = e0_r.out_byte;
  assign out_ch.byte_valid = e0_r.byte_valid;
  assign out_ch.run_last   = e0_r.run_last;
  assign out_ch.text_end   = e0_r.text_end;

endmodule

`default_nettype wire

@@ rtl/html_tag_stripper.sv @@
// Streaming html tag stripper. Bytes enter a nine-cell window chain; the head
// cell is judged against script/style open and close patterns and tag
// brackets, one position per cycle while the queue is not full. While text
// streams in, one byte is taken every cycle unless window and queue are both
// full, and each byte leaves a result at most; the first judgement waits for
// the ninth byte, and each result is registered in the queue before it is
// offered. After a transfer with in_last set, input is held off while the window
// drains its pending bytes (up to nine) through the single judge at the head of
// the chain, then closes the text. Results pass through a two-entry queue, so
// a stalled output only holds off input once both entries are taken.
// depends on hts_pkg, hts_ifs, hts_cell and hts_outq
`default_nettype none

module html_tag_stripper (
  input  wire      clk,
  input  wire      rst_n,
  hts_in_if.sink   in_ch,
  hts_out_if.source out_ch
);
  import hts_pkg::*;

  fill_t fill_r, fill_nxt;
  fill_t skip_r, skip_nxt;
  logic  tag_r, tag_nxt;
  logic  script_r, script_nxt;
  logic  style_r, style_nxt;
  logic  drain_r, drain_nxt;
  logic  held_v_r, held_v_nxt;
  byte_t held_r, held_nxt;

  logic  q_full;
  logic  judge;
  logic  finish;
  logic  acc;
  fill_t widx;

  byte_t    cell_data [WIN_DEPTH];
  byte_t    cell_nb   [WIN_DEPTH];
  pat_hit_t cell_hit  [WIN_DEPTH];

  logic m_so, m_sc, m_yo, m_yc;

  logic  emit;
  byte_t ob;
  fill_t j_skip;
  logic  j_tag, j_script, j_style;

  logic push;
  res_t push_data;

  // control
  assign judge  = !q_full && (drain_r ? (fill_r != 4'd0) : (fill_r == FILL_FULL));
  assign finish = !q_full && drain_r && (fill_r == 4'd0);
  assign in_ch.ready = !drain_r && ((fill_r != FILL_FULL) || !q_full);
  assign acc    = in_ch.valid && in_ch.ready;
  assign widx   = fill_r - {3'b000, judge};

  // window chain
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == WIN_DEPTH - 1) begin : g_tail
      assign cell_nb[i] = 8'h00;
    end else begin : g_mid
      assign cell_nb[i] = cell_data[i+1];
    end

    hts_cell u_cell (
      .clk       (clk),
      .wr_i      (acc && (widx == 4'(i))),
      .shift_i   (judge),
      .nb_i      (cell_nb[i]),
      .in_byte_i (in_ch.in_byte),
      .pat_i     (pat_col(i)),
      .data_o    (cell_data[i]),
      .hit_o     (cell_hit[i])
    );
  end

  // pattern match at the head, only for patterns that fit
  always_comb begin
    m_so = (fill_r >= LEN_SCRIPT_OPEN);
    m_sc = (fill_r >= LEN_SCRIPT_CLOSE);
    m_yo = (fill_r >= LEN_STYLE_OPEN);
    m_yc = (fill_r >= LEN_STYLE_CLOSE);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (4'(i) < LEN_SCRIPT_OPEN)  m_so = m_so && cell_hit[i][P_SCRIPT_OPEN];
      if (4'(i) < LEN_SCRIPT_CLOSE) m_sc = m_sc && cell_hit[i][P_SCRIPT_CLOSE];
      if (4'(i) < LEN_STYLE_OPEN)   m_yo = m_yo && cell_hit[i][P_STYLE_OPEN];
      if (4'(i) < LEN_STYLE_CLOSE)  m_yc = m_yc && cell_hit[i][P_STYLE_CLOSE];
    end
  end

  // judge the head position
  always_comb begin
    emit     = 1'b0;
    ob       = cell_data[0];
    j_skip   = skip_r;
    j_tag    = tag_r;
    j_script = script_r;
    j_style  = style_r;
    if (skip_r != 4'd0) begin
      j_skip = skip_r - 4'd1;
    end else begin
      j_script = script_r || m_so;
      if (m_sc) begin
        j_script = 1'b0;
        j_skip   = SKIP_SCRIPT;
      end else if (!j_script) begin
        j_style = style_r || m_yo;
        if (m_yc) begin
          j_style = 1'b0;
          j_skip  = SKIP_STYLE;
        end else if (!j_style) begin
          if (cell_data[0] == CH_LT) begin
            j_tag = 1'b1;
            emit  = 1'b1;
            ob    = CH_SPACE;
          end else if (cell_data[0] == CH_GT) begin
            j_tag = 1'b0;
          end else if (!tag_r) begin
            emit = 1'b1;
          end
        end
      end
    end
  end

  // next state
  always_comb begin
    fill_nxt   = fill_r - {3'b000, judge} + {3'b000, acc};
    skip_nxt   = skip_r;
    tag_nxt    = tag_r;
    script_nxt = script_r;
    style_nxt  = style_r;
    drain_nxt  = drain_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (acc && in_ch.in_last) begin
      drain_nxt = 1'b1;
    end
    if (judge) begin
      skip_nxt   = j_skip;
      tag_nxt    = j_tag;
      script_nxt = j_script;
      style_nxt  = j_style;
      if (drain_r && emit) begin
        held_nxt   = ob;
        held_v_nxt = 1'b1;
      end
    end
    if (finish) begin
      skip_nxt   = 4'd0;
      tag_nxt    = 1'b0;
      script_nxt = 1'b0;
      style_nxt  = 1'b0;
      drain_nxt  = 1'b0;
      held_v_nxt = 1'b0;
    end
  end

  // results into the queue
  always_comb begin
    push      = 1'b0;
    push_data = '{out_byte: ob, byte_valid: 1'b1, run_last: 1'b1, text_end: 1'b0};
    if (judge && !drain_r && emit) begin
      push = 1'b1;
    end else if (judge && drain_r && emit && held_v_r) begin
      push      = 1'b1;
      push_data = '{out_byte: held_r, byte_valid: 1'b1, run_last: 1'b0, text_end: 1'b0};
    end else if (finish) begin
      push      = 1'b1;
      push_data = '{out_byte: held_v_r ? held_r : 8'h00, byte_valid: held_v_r,
                    run_last: 1'b1, text_end: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 4'd0;
      skip_r   <= 4'd0;
      tag_r    <= 1'b0;
      script_r <= 1'b0;
      style_r  <= 1'b0;
      drain_r  <= 1'b0;
      held_v_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      skip_r   <= skip_nxt;
      tag_r    <= tag_nxt;
      script_r <= script_nxt;
      style_r  <= style_nxt;
      drain_r  <= drain_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  hts_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .data_i (push_data),
    .full_o (q_full),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/hts_chk.sv @@
// port-level checker for the html tag stripper, bound to the top level
// depends on html_tag_stripper_macros.svh and html_tag_stripper
`default_nettype none

`include "html_tag_stripper_macros.svh"

module hts_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_last,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       byte_valid,
  input wire       run_last,
  input wire       text_end
);

  `HTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

  `HTS_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid && text_end, run_last, "text end without run last")

  `HTS_ASSERT_NOW(a_empty_marker, clk, rst_n, out_valid && !byte_valid, text_end && (out_byte == 8'h00), "empty result that is not an end marker")

  `HTS_ASSERT_NEXT(a_drain_blocks, clk, rst_n, in_valid && in_ready && in_last, !in_ready, "input taken during drain")

endmodule

bind html_tag_stripper hts_chk u_hts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.in_last),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .run_last   (out_ch.run_last),
  .text_end   (out_ch.text_end)
);

`default_nettype wire
